// ===== design/mlpbp_pkg.sv =====
`timescale 1ns / 1ps
package mlpbp_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int WEIGHT_COUNT = 9;
    localparam int SIG_DEPTH    = 256;
    localparam int SIG_IDX_W    = $clog2(SIG_DEPTH);
    localparam int IDX_SHIFT    = FRAC_BITS + 4 - SIG_IDX_W;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int W_W          = 16;
    localparam int IDX_W        = 4;
    localparam int MUL_W        = 20;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ONE_Q        = 1 << FRAC_BITS;
    localparam int LR_W         = 13;
    localparam int ERR_W        = 24;
    localparam int ERR_CAP      = 8388608;
    localparam int SQ_SHIFT     = 2 * FRAC_BITS - 23;
    localparam int SQE_W        = 2 * Q_W - SQ_SHIFT;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE,
        ACT_READ,
        ACT_TRAIN,
        ACT_NONE
    } action_t;

    typedef enum logic [4:0] {
        UOP_HA0, UOP_HA1, UOP_HA2,
        UOP_HB0, UOP_HB1, UOP_HB2,
        UOP_P0,  UOP_P1,  UOP_P2,
        UOP_SQ,
        UOP_D0,  UOP_D1,  UOP_D2,  UOP_D3,  UOP_D4,  UOP_D5,
        UOP_D6,  UOP_D7,  UOP_D8,  UOP_D9,  UOP_D10, UOP_D11,
        UOP_D12, UOP_D13, UOP_D14, UOP_D15, UOP_D16
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_WB,
        ST_CHECK,
        ST_UPDATE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic wb;
        logic update;
        logic finish;
        uop_t uop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic train;
        logic below;
        logic out_free;
    } dp_sts_t;

    typedef logic [Q_W-1:0] sig_tab_t [SIG_DEPTH];

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at each cell center over [-8, 8), rounded to nearest in Q0.F.
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t    tab;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        logic        neg;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            v   = (64'(2 * k + 1) << 36) / (2 * SIG_DEPTH);
            neg = v < (64'd8 << 32);
            a   = neg ? ((64'd8 << 32) - v) : (v - (64'd8 << 32));
            x   = a >> 8;
            x2  = (x * x) >> 32;
            e   = (64'd1 << 32) - x + ((x * x) >> 33) - (((x2 * x) >> 32) / 6);
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            for (int i = 0; i < 8; i++)
                e = (e * e) >> 32;
            den = (64'd1 << 32) + e;
            s   = udiv64((64'd1 << (FRAC_BITS + 32)) + (den >> 1), den);
            tab[k] = neg ? Q_W'(64'(ONE_Q) - s) : Q_W'(s);
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// ===== design/mlpbp_ctrl.sv =====
`timescale 1ns / 1ps
module mlpbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mlpbp_pkg::dp_sts_t    sts,
    output mlpbp_pkg::ctrl_cmd_t  cmd
);
    import mlpbp_pkg::*;

    state_t state_reg;
    state_t state_next;
    uop_t   uop_reg;
    uop_t   uop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            uop_reg   <= UOP_HA0;
        end
        else
        begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                uop_next   = UOP_HA0;
                state_next = sts.train ? ST_MUL : ST_FIN;
            end
            ST_MUL:
                state_next = ST_WB;
            ST_WB:
            begin
                if (uop_reg == UOP_D16)
                    state_next = ST_UPDATE;
                else
                begin
                    uop_next   = uop_t'(uop_reg + 5'd1);
                    state_next = (uop_reg == UOP_SQ) ? ST_CHECK : ST_MUL;
                end
            end
            ST_CHECK:
                state_next = sts.below ? ST_FIN : ST_MUL;
            ST_UPDATE:
                state_next = ST_FIN;
            ST_FIN:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mul     = (state_reg == ST_MUL);
        cmd.wb      = (state_reg == ST_WB);
        cmd.update  = (state_reg == ST_UPDATE);
        cmd.finish  = (state_reg == ST_FIN) && sts.out_free;
        cmd.uop     = uop_reg;
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result loaded while output register full");

    a_update_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !sts.below) |=> (state_reg == ST_MUL && uop_reg == UOP_D0))
        else $error("back-propagation did not start after error check");

    a_mul_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_WB && $stable(uop_reg)))
        else $error("product not written back");

endmodule

// ===== design/mlpbp_dp.sv =====
`timescale 1ns / 1ps
module mlpbp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlpbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlpbp_pkg::ERR_W-1:0]         cfg_data,
    input  logic [mlpbp_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mlpbp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  mlpbp_pkg::ctrl_cmd_t                cmd,
    output mlpbp_pkg::dp_sts_t                  sts
);
    import mlpbp_pkg::*;

    logic signed [W_W-1:0]    w_reg [WEIGHT_COUNT];
    logic signed [MUL_W-1:0]  dw_reg [WEIGHT_COUNT];
    logic [LR_W-1:0]          lr_reg;
    logic [ERR_W-1:0]         thr_reg;
    action_t                  act_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [W_W-1:0]    wv_reg;
    logic [Q_W-1:0]           x0_reg;
    logic [Q_W-1:0]           x1_reg;
    logic [Q_W-1:0]           tg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [Q_W-1:0]           ha_reg;
    logic [Q_W-1:0]           hb_reg;
    logic [Q_W-1:0]           p_reg;
    logic [SQE_W-1:0]         err_reg;
    logic signed [MUL_W-1:0]  t0_reg;
    logic signed [MUL_W-1:0]  t1_reg;
    logic signed [MUL_W-1:0]  dout_reg;
    logic signed [MUL_W-1:0]  da_reg;
    logic signed [MUL_W-1:0]  db_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_next;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [MUL_W-1:0]  one_s;
    logic signed [MUL_W-1:0]  x0_s;
    logic signed [MUL_W-1:0]  x1_s;
    logic signed [MUL_W-1:0]  tg_s;
    logic signed [MUL_W-1:0]  ha_s;
    logic signed [MUL_W-1:0]  hb_s;
    logic signed [MUL_W-1:0]  p_s;
    logic signed [MUL_W-1:0]  lr_s;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [MUL_W-1:0]  fm;
    logic signed [PROD_W-1:0] acc_sum;
    logic                     below;
    logic                     idx_ok;

    function automatic logic [Q_W-1:0] sig_lookup(input logic signed [PROD_W-1:0] sum);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] hi;
        logic [SIG_IDX_W-1:0]     k;
        t  = (sum >>> FRAC_BITS) + $signed(PROD_W'(8 << FRAC_BITS));
        hi = t >>> IDX_SHIFT;
        if (t < 0)
            k = '0;
        else if (hi > $signed(PROD_W'(SIG_DEPTH - 1)))
            k = SIG_IDX_W'(SIG_DEPTH - 1);
        else
            k = t[IDX_SHIFT +: SIG_IDX_W];
        return SIG_TAB[k];
    endfunction

    assign one_s   = MUL_W'(ONE_Q);
    assign x0_s    = MUL_W'(x0_reg);
    assign x1_s    = MUL_W'(x1_reg);
    assign tg_s    = MUL_W'(tg_reg);
    assign ha_s    = MUL_W'(ha_reg);
    assign hb_s    = MUL_W'(hb_reg);
    assign p_s     = MUL_W'(p_reg);
    assign lr_s    = MUL_W'(lr_reg);
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign fm      = MUL_W'(prod_sh);
    assign acc_sum = acc_reg + prod_reg;
    assign below   = err_reg < SQE_W'(thr_reg);
    assign idx_ok  = idx_reg < IDX_W'(WEIGHT_COUNT);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.uop)
            UOP_HA0: begin op_a = MUL_W'(w_reg[0]); op_b = x0_s;  end
            UOP_HA1: begin op_a = MUL_W'(w_reg[2]); op_b = x1_s;  end
            UOP_HA2: begin op_a = MUL_W'(w_reg[4]); op_b = one_s; end
            UOP_HB0: begin op_a = MUL_W'(w_reg[1]); op_b = x0_s;  end
            UOP_HB1: begin op_a = MUL_W'(w_reg[3]); op_b = x1_s;  end
            UOP_HB2: begin op_a = MUL_W'(w_reg[5]); op_b = one_s; end
            UOP_P0:  begin op_a = MUL_W'(w_reg[6]); op_b = ha_s;  end
            UOP_P1:  begin op_a = MUL_W'(w_reg[7]); op_b = hb_s;  end
            UOP_P2:  begin op_a = MUL_W'(w_reg[8]); op_b = one_s; end
            UOP_SQ:  begin op_a = p_s - tg_s;       op_b = p_s - tg_s; end
            UOP_D0:  begin op_a = p_s;              op_b = one_s - p_s; end
            UOP_D1:  begin op_a = t0_reg;           op_b = tg_s - p_s;  end
            UOP_D2:  begin op_a = dout_reg;         op_b = MUL_W'(w_reg[6]); end
            UOP_D3:  begin op_a = ha_s;             op_b = one_s - ha_s; end
            UOP_D4:  begin op_a = t1_reg;           op_b = t0_reg; end
            UOP_D5:  begin op_a = dout_reg;         op_b = MUL_W'(w_reg[7]); end
            UOP_D6:  begin op_a = hb_s;             op_b = one_s - hb_s; end
            UOP_D7:  begin op_a = t1_reg;           op_b = t0_reg; end
            UOP_D8:  begin op_a = lr_s;             op_b = da_reg; end
            UOP_D9:  begin op_a = lr_s;             op_b = db_reg; end
            UOP_D10: begin op_a = lr_s;             op_b = dout_reg; end
            UOP_D11: begin op_a = dw_reg[4];        op_b = x0_s; end
            UOP_D12: begin op_a = dw_reg[4];        op_b = x1_s; end
            UOP_D13: begin op_a = dw_reg[5];        op_b = x0_s; end
            UOP_D14: begin op_a = dw_reg[5];        op_b = x1_s; end
            UOP_D15: begin op_a = dw_reg[8];        op_b = ha_s; end
            UOP_D16: begin op_a = dw_reg[8];        op_b = hb_s; end
            default: begin op_a = '0;               op_b = '0;   end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_W'(819);
            thr_reg <= ERR_W'(167772);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE:   lr_reg  <= cfg_data[LR_W-1:0];
                CFG_ERROR_THRESHOLD: thr_reg <= cfg_data;
                default:             lr_reg  <= lr_reg;
            endcase
        end
    end

    // Weight store: write on finish, saturated add on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WEIGHT_COUNT; i++)
                w_reg[i] <= '0;
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < WEIGHT_COUNT; i++)
            begin
                if ((MUL_W + 1)'(w_reg[i]) + (MUL_W + 1)'(dw_reg[i]) > (MUL_W + 1)'(32767))
                    w_reg[i] <= W_W'(32767);
                else if ((MUL_W + 1)'(w_reg[i]) + (MUL_W + 1)'(dw_reg[i])
                         < -(MUL_W + 1)'(32768))
                    w_reg[i] <= W_W'(-32768);
                else
                    w_reg[i] <= W_W'((MUL_W + 1)'(w_reg[i]) + (MUL_W + 1)'(dw_reg[i]));
            end
        end
        else if (cmd.finish && act_reg == ACT_WRITE && idx_ok)
            w_reg[idx_reg] <= wv_reg;
    end

    // Item capture and shared multiplier datapath
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action_t'(s_tuser);
            idx_reg <= s_tdata[3:0];
            wv_reg  <= s_tdata[19:4];
            x0_reg  <= s_tdata[32:20];
            x1_reg  <= s_tdata[45:33];
            tg_reg  <= s_tdata[58:46];
        end
        if (cmd.mul)
            prod_reg <= op_a * op_b;
        if (cmd.wb)
        begin
            case (cmd.uop)
                UOP_HA0, UOP_HB0, UOP_P0: acc_reg <= prod_reg;
                UOP_HA1, UOP_HB1, UOP_P1: acc_reg <= acc_sum;
                UOP_HA2: ha_reg   <= sig_lookup(acc_sum);
                UOP_HB2: hb_reg   <= sig_lookup(acc_sum);
                UOP_P2:  p_reg    <= sig_lookup(acc_sum);
                UOP_SQ:  err_reg  <= prod_reg[2*Q_W-1:SQ_SHIFT];
                UOP_D0:  t0_reg   <= fm;
                UOP_D1:  dout_reg <= fm;
                UOP_D2:  t0_reg   <= fm;
                UOP_D3:  t1_reg   <= fm;
                UOP_D4:  da_reg   <= fm;
                UOP_D5:  t0_reg   <= fm;
                UOP_D6:  t1_reg   <= fm;
                UOP_D7:  db_reg   <= fm;
                UOP_D8:  dw_reg[4] <= fm;
                UOP_D9:  dw_reg[5] <= fm;
                UOP_D10: dw_reg[8] <= fm;
                UOP_D11: dw_reg[0] <= fm;
                UOP_D12: dw_reg[2] <= fm;
                UOP_D13: dw_reg[1] <= fm;
                UOP_D14: dw_reg[3] <= fm;
                UOP_D15: dw_reg[6] <= fm;
                UOP_D16: dw_reg[7] <= fm;
                default: acc_reg  <= acc_reg;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_comb
    begin
        m_tdata_next = '0;
        case (act_reg)
            ACT_READ:
            begin
                if (idx_ok)
                    m_tdata_next[53:38] = w_reg[idx_reg];
            end
            ACT_TRAIN:
            begin
                m_tdata_next[12:0]  = p_reg;
                m_tdata_next[36:13] = (err_reg > SQE_W'(ERR_CAP)) ? ERR_W'(ERR_CAP)
                                                                  : err_reg[ERR_W-1:0];
                m_tdata_next[37]    = below;
            end
            default:
                m_tdata_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.train    = (act_reg == ACT_TRAIN);
    assign sts.below    = below;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== design/mlp_2_2_1_backprop_step.sv =====
`timescale 1ns / 1ps
// Training step of a 2-2-1 sigmoid perceptron with nine on-chip Q4.12 weights.
// Slave channel: one transaction per action; s_tuser selects write weight,
// read weight or train, s_tdata carries index, value, two inputs and target.
// Master channel: one transaction per accepted item with prediction, half
// squared error, within-limit flag and weight readback.
// cfg_we/cfg_index/cfg_data set learning rate (0) and error threshold (1);
// write them only while the block is idle.
// After acceptance, write and read items go from load to finish; a train item
// runs its forward products and squared error, then back-propagation and the
// weight update only if the error is not below threshold. The next item is taken
// only after finish. The single shared 20x20 multiplier does each of the 27
// products as an issue step and a write-back step, in dependency order.
// Reset clears the weights to zero, restores the default registers and empties
// the output register. While the receiver stalls, the result holds in the
// output register; the next item is still accepted and processed, and its
// result waits until the register frees.
module mlp_2_2_1_backprop_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlpbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlpbp_pkg::ERR_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // weight_index[3:0], weight_value[19:4], first_input[32:20],
    // second_input[45:33], target[58:46], zero fill above
    input  logic [mlpbp_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // prediction[12:0], half_sq_error[36:13], within_limit[37],
    // weight_readback[53:38], zero fill above
    output logic [mlpbp_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import mlpbp_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Sequence the multiply steps and the output handoff
    mlpbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold weights, operands, shared multiplier and output register
    mlpbp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
